// ===== hw/rtl/euler_state_converter_unit_assert.svh =====
// assertion macros shared by the euler state converter modules
`ifndef EULER_STATE_CONVERTER_UNIT_ASSERT_SVH
`define EULER_STATE_CONVERTER_UNIT_ASSERT_SVH

// checked on every clock edge outside reset
`define ESC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("euler state converter assertion failed");

// checked on every clock edge, reset included
`define ESC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("euler state converter assertion failed");

`endif

// ===== hw/rtl/esc_pkg.sv =====
// types and constants of the euler state converter
`default_nettype none

package esc_pkg;

  localparam int DATA_W     = 32;
  localparam int TAG_W      = 10;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int GM1_W      = 17;
  localparam int IGM1_W     = 31;
  localparam int GAS_W      = 31;

  // long divider geometry
  localparam int NUM_W = 64;
  localparam int DEN_W = 62;
  localparam int QUO_W = 33;

  localparam logic [MODE_W-1:0] MODE_C2P  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_P2C  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEMP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GAMMA_M1     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_GAMMA_M1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAS_CONST    = 2'd2;

  localparam logic [GM1_W-1:0]  GM1_RESET  = 17'd26214;
  localparam logic [IGM1_W-1:0] IGM1_RESET = 31'd163840;
  localparam logic [GAS_W-1:0]  GAS_RESET  = 31'd18808832;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] in_density;
    logic signed [DATA_W-1:0] in_first;
    logic signed [DATA_W-1:0] in_second;
    logic signed [DATA_W-1:0] in_energy_or_pressure;
    logic [TAG_W-1:0]         cell_col;
    logic [TAG_W-1:0]         cell_row;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_density;
    logic signed [DATA_W-1:0] out_first;
    logic signed [DATA_W-1:0] out_second;
    logic signed [DATA_W-1:0] out_energy_or_pressure;
    logic [TAG_W-1:0]         tag_col;
    logic [TAG_W-1:0]         tag_row;
    logic                     density_fault;
    logic                     saturated;
  } result_t;

  // one lane of the restoring divider
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             ovf;
  } div_lane_t;

  // item data that rides alongside the divider
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic                     fault;
    logic                     neg_a;
    logic                     neg_b;
    logic signed [DATA_W-1:0] rho;
    logic signed [DATA_W-1:0] f1;
    logic signed [DATA_W-1:0] f2;
    logic signed [DATA_W-1:0] f3;
    logic [TAG_W-1:0]         tag_col;
    logic [TAG_W-1:0]         tag_row;
  } side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/euler_state_converter_unit.sv =====
// top level of the euler conservative / primitive state converter
// done follows the operand setup registers, the 64-stage divider and the tail stages
// throughput: one cell per cycle, busy is low whenever reset is released
// results cannot be held off: each result stands on the ports for one cycle with done
// reset: synchronous rst flushes every stage and restores the gas parameters
`default_nettype none

module euler_state_converter_unit (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  output logic                                busy,
  input  wire esc_pkg::item_t                 item,
  output logic                                done,
  output esc_pkg::result_t                    result,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [esc_pkg::CFG_DATA_W-1:0] cfg_data
);

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    return x[31] ? ((~x) + 32'd1) : x;
  endfunction

  logic [esc_pkg::GM1_W-1:0]  gm1;
  logic [esc_pkg::IGM1_W-1:0] igm1;
  logic [esc_pkg::GAS_W-1:0]  gas;

  logic                           a_vld;
  esc_pkg::item_t                 a_item;
  logic                           b_vld;
  esc_pkg::div_lane_t [1:0]       b_lane;
  esc_pkg::side_t                 b_side;
  esc_pkg::div_lane_t [1:0]       b_lane_next;
  esc_pkg::side_t                 b_side_next;

  logic                           rho_pos;
  logic [61:0]                    den_temp;

  logic                           d_vld;
  esc_pkg::div_lane_t [1:0]       d_lane;
  logic [$bits(esc_pkg::side_t)-1:0] d_side;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      gm1  <= esc_pkg::GM1_RESET;
      igm1 <= esc_pkg::IGM1_RESET;
      gas  <= esc_pkg::GAS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        esc_pkg::REG_GAMMA_M1:     gm1  <= cfg_data[esc_pkg::GM1_W-1:0];
        esc_pkg::REG_INV_GAMMA_M1: igm1 <= cfg_data;
        esc_pkg::REG_GAS_CONST:    gas  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // operand setup: magnitudes, divisors and the fault decision
  always_comb begin
    rho_pos  = (a_item.in_density > 32'sd0);
    den_temp = gas * a_item.in_density[30:0];

    b_side_next         = '0;
    b_side_next.mode    = a_item.mode;
    b_side_next.fault   = ((a_item.mode == esc_pkg::MODE_C2P) && !rho_pos) ||
                          ((a_item.mode == esc_pkg::MODE_TEMP) && (!rho_pos || (gas == '0)));
    b_side_next.neg_a   = (a_item.mode == esc_pkg::MODE_TEMP) ?
                          a_item.in_energy_or_pressure[31] : a_item.in_first[31];
    b_side_next.neg_b   = a_item.in_second[31];
    b_side_next.rho     = a_item.in_density;
    b_side_next.f1      = a_item.in_first;
    b_side_next.f2      = a_item.in_second;
    b_side_next.f3      = a_item.in_energy_or_pressure;
    b_side_next.tag_col = a_item.cell_col;
    b_side_next.tag_row = a_item.cell_row;

    b_lane_next        = '0;
    b_lane_next[0].den = 62'd1;
    b_lane_next[1].den = 62'd1;
    if (!b_side_next.fault) begin
      case (a_item.mode)
        esc_pkg::MODE_C2P: begin
          b_lane_next[0].num = {16'b0, abs32(a_item.in_first), 16'b0};
          b_lane_next[0].den = {31'b0, a_item.in_density[30:0]};
          b_lane_next[1].num = {16'b0, abs32(a_item.in_second), 16'b0};
          b_lane_next[1].den = {31'b0, a_item.in_density[30:0]};
        end
        esc_pkg::MODE_TEMP: begin
          b_lane_next[0].num = {abs32(a_item.in_energy_or_pressure), 32'b0};
          b_lane_next[0].den = den_temp;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
      b_vld <= a_vld;
    end
    a_item <= item;
    b_lane <= b_lane_next;
    b_side <= b_side_next;
  end

  esc_div #(
    .LANES  (2),
    .SIDE_W ($bits(esc_pkg::side_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_vld),
    .in_lane   (b_lane),
    .in_side   (b_side),
    .out_valid (d_vld),
    .out_lane  (d_lane),
    .out_side  (d_side)
  );

  esc_tail u_tail (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_vld),
    .in_side  (esc_pkg::side_t'(d_side)),
    .in_lane  (d_lane),
    .gm1      (gm1),
    .igm1     (igm1),
    .done     (done),
    .result   (result)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/esc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with sideband
`default_nettype none

`include "euler_state_converter_unit_assert.svh"

module esc_div #(
  parameter int LANES  = 2,
  parameter int SIDE_W = 1
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  input  wire esc_pkg::div_lane_t [LANES-1:0]  in_lane,
  input  wire logic [SIDE_W-1:0]               in_side,
  output logic                                 out_valid,
  output esc_pkg::div_lane_t [LANES-1:0]       out_lane,
  output logic [SIDE_W-1:0]                    out_side
);

  localparam int STAGES = esc_pkg::NUM_W;
  localparam int NW     = esc_pkg::NUM_W;
  localparam int DW     = esc_pkg::DEN_W;
  localparam int QW     = esc_pkg::QUO_W;

  function automatic esc_pkg::div_lane_t div_step(input esc_pkg::div_lane_t a);
    esc_pkg::div_lane_t r;
    logic [DW:0] trial;
    logic [DW:0] dext;
    logic [DW:0] diff;
    r     = a;
    trial = {a.rem, a.num[NW-1]};
    dext  = {1'b0, a.den};
    diff  = trial - dext;
    r.num = {a.num[NW-2:0], 1'b0};
    // quotient bits beyond the kept width only matter as overflow
    r.ovf = a.ovf | a.quo[QW-1];
    if (trial >= dext) begin
      r.rem = diff[DW-1:0];
      r.quo = {a.quo[QW-2:0], 1'b1};
    end else begin
      r.rem = trial[DW-1:0];
      r.quo = {a.quo[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  logic                               vld [1:STAGES];
  esc_pkg::div_lane_t [LANES-1:0]     ln  [1:STAGES];
  logic [SIDE_W-1:0]                  sd  [1:STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_st
    logic                           pv;
    esc_pkg::div_lane_t [LANES-1:0] pl;
    logic [SIDE_W-1:0]              ps;
    esc_pkg::div_lane_t [LANES-1:0] nx;

    if (s == 0) begin : g_src_in
      assign pv = in_valid;
      assign pl = in_lane;
      assign ps = in_side;
    end else begin : g_src_prev
      assign pv = vld[s];
      assign pl = ln[s];
      assign ps = sd[s];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        nx[l] = div_step(pl[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= pv;
      end
      ln[s+1] <= nx;
      sd[s+1] <= ps;
    end
  end

  assign out_valid = vld[STAGES];
  assign out_lane  = ln[STAGES];
  assign out_side  = sd[STAGES];

  `ESC_ASSERT(a_rem_below_den, out_valid |-> (out_lane[0].rem < out_lane[0].den))
  `ESC_ASSERT(a_num_drained, out_valid |-> (out_lane[0].num == '0))
  `ESC_ASSERT_ALWAYS(a_reset_clears, $past(rst) |-> !out_valid)

endmodule

`default_nettype wire

// ===== hw/rtl/esc_tail.sv =====
// quotient finish, kinetic energy, momentum, pressure and energy stages
`default_nettype none

`include "euler_state_converter_unit_assert.svh"

module esc_tail (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  input  wire esc_pkg::side_t             in_side,
  input  wire esc_pkg::div_lane_t [1:0]   in_lane,
  input  wire logic [esc_pkg::GM1_W-1:0]  gm1,
  input  wire logic [esc_pkg::IGM1_W-1:0] igm1,
  output logic                            done,
  output esc_pkg::result_t                result
);

  localparam int TAIL_ST = 7;
  localparam logic signed [63:0] Q_MAX64    = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN64    = -64'sd2147483648;
  localparam logic signed [63:0] MULQ_LIM   = 64'sd140737488355328;
  localparam logic [31:0]        Q_MAX32    = 32'h7fff_ffff;
  localparam logic [31:0]        Q_MIN32    = 32'h8000_0000;
  localparam logic [32:0]        QUO_POS_LIM = 33'h0_7fff_ffff;
  localparam logic [32:0]        QUO_NEG_LIM = 33'h0_8000_0000;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } clip_t;

  typedef struct packed {
    logic [esc_pkg::MODE_W-1:0] mode;
    logic                       fault;
    logic                       sat;
    logic [esc_pkg::TAG_W-1:0]  tag_col;
    logic [esc_pkg::TAG_W-1:0]  tag_row;
    logic signed [31:0]         rho;
    logic signed [31:0]         f3;
    logic signed [31:0]         r0;
    logic signed [31:0]         u;
    logic signed [31:0]         v;
    logic signed [31:0]         r1;
    logic signed [31:0]         r2;
    logic signed [31:0]         r3;
    logic signed [63:0]         uu;
    logic signed [63:0]         vv;
    logic signed [63:0]         mom1;
    logic signed [63:0]         mom2;
    logic signed [63:0]         pep;
    logic [47:0]                s;
    logic signed [47:0]         pe;
    logic signed [63:0]         pa;
    logic signed [47:0]         pb;
    logic signed [63:0]         ke;
    logic signed [63:0]         acc;
    logic signed [66:0]         prod;
    logic                       big;
  } tail_t;

  function automatic clip_t clip64(input logic signed [63:0] x);
    clip_t c;
    c.sat = 1'b0;
    c.val = x[31:0];
    if (x > Q_MAX64) begin
      c.sat = 1'b1;
      c.val = Q_MAX32;
    end else if (x < Q_MIN64) begin
      c.sat = 1'b1;
      c.val = Q_MIN32;
    end
    return c;
  endfunction

  // truncated quotient with sign applied, clipped to q16.16
  function automatic clip_t div_fin(input logic neg, input logic [32:0] quo, input logic ovf);
    clip_t c;
    c.sat = 1'b0;
    if (neg) begin
      c.val = (~quo[31:0]) + 32'd1;
      if (ovf || (quo > QUO_NEG_LIM)) begin
        c.sat = 1'b1;
        c.val = Q_MIN32;
      end
    end else begin
      c.val = quo[31:0];
      if (ovf || (quo > QUO_POS_LIM)) begin
        c.sat = 1'b1;
        c.val = Q_MAX32;
      end
    end
    return c;
  endfunction

  tail_t q1, q2, q3, q4, q5, q6, q7;
  tail_t n1, n2, n3, n4, n5, n6, n7;
  esc_pkg::result_t res;
  logic [TAIL_ST-1:0] vld;

  // stage 1: finish the quotients, pick the velocities
  always_comb begin
    clip_t fa;
    clip_t fb;
    fa = div_fin(in_side.neg_a, in_lane[0].quo, in_lane[0].ovf);
    fb = div_fin(in_side.neg_b, in_lane[1].quo, in_lane[1].ovf);
    n1         = '0;
    n1.mode    = in_side.mode;
    n1.fault   = in_side.fault;
    n1.tag_col = in_side.tag_col;
    n1.tag_row = in_side.tag_row;
    n1.rho     = in_side.rho;
    n1.f3      = in_side.f3;
    case (in_side.mode)
      esc_pkg::MODE_C2P: begin
        n1.r0  = in_side.rho;
        n1.u   = fa.val;
        n1.v   = fb.val;
        n1.r1  = fa.val;
        n1.r2  = fb.val;
        n1.sat = fa.sat | fb.sat;
      end
      esc_pkg::MODE_P2C: begin
        n1.r0 = in_side.rho;
        n1.u  = in_side.f1;
        n1.v  = in_side.f2;
      end
      esc_pkg::MODE_TEMP: begin
        n1.r0  = fa.val;
        n1.sat = fa.sat;
      end
      default: begin
      end
    endcase
  end

  // stage 2: squares and products
  always_comb begin
    n2      = q1;
    n2.uu   = q1.u * q1.u;
    n2.vv   = q1.v * q1.v;
    n2.mom1 = q1.rho * q1.u;
    n2.mom2 = q1.rho * q1.v;
    n2.pep  = q1.f3 * $signed({1'b0, igm1});
  end

  // stage 3: speed sum, momentum clipping, pressure term of the energy
  always_comb begin
    clip_t c1;
    clip_t c2;
    logic signed [63:0] pe_full;
    c1      = clip64(q2.mom1 >>> 16);
    c2      = clip64(q2.mom2 >>> 16);
    pe_full = q2.pep >>> 16;
    n3      = q2;
    n3.s    = q2.uu[63:16] + q2.vv[63:16];
    n3.pe   = pe_full[47:0];
    if (q2.mode == esc_pkg::MODE_P2C) begin
      n3.r1  = c1.val;
      n3.r2  = c2.val;
      n3.sat = q2.sat | c1.sat | c2.sat;
    end
  end

  // stage 4: density times speed sum as two partial products
  always_comb begin
    n4    = q3;
    n4.pa = q3.rho * $signed({1'b0, q3.s[47:16]});
    n4.pb = q3.rho * $signed({1'b0, q3.s[15:0]});
  end

  // stage 5: kinetic energy, floor of rho * s / 2^17
  always_comb begin
    logic signed [79:0] tot;
    logic signed [79:0] ke_full;
    tot     = (80'(q4.pa) <<< 16) + 80'(q4.pb);
    ke_full = tot >>> 17;
    n5      = q4;
    n5.ke   = ke_full[63:0];
  end

  // stage 6: internal energy for pressure, or total energy
  always_comb begin
    n6 = q5;
    if (q5.mode == esc_pkg::MODE_C2P) begin
      n6.acc = 64'(q5.f3) - q5.ke;
    end else begin
      n6.acc = 64'(q5.pe) + q5.ke;
    end
  end

  // stage 7: scale by gamma minus one, clip the energy
  always_comb begin
    clip_t ce;
    ce      = clip64(q6.acc);
    n7      = q6;
    n7.big  = ((q6.acc > MULQ_LIM) || (q6.acc < -MULQ_LIM)) && (gm1 != '0);
    n7.prod = $signed(q6.acc[48:0]) * $signed({1'b0, gm1});
    if (q6.mode == esc_pkg::MODE_P2C) begin
      n7.r3  = ce.val;
      n7.sat = q6.sat | ce.sat;
    end
  end

  // final: pressure clip and fault blanking
  always_comb begin
    clip_t cp;
    logic signed [66:0] pr;
    pr  = q7.prod >>> 16;
    cp  = clip64(pr[63:0]);
    res = '0;
    res.tag_col = q7.tag_col;
    res.tag_row = q7.tag_row;
    if (q7.fault) begin
      res.density_fault = 1'b1;
    end else begin
      res.out_density            = q7.r0;
      res.out_first              = q7.r1;
      res.out_second             = q7.r2;
      res.out_energy_or_pressure = q7.r3;
      res.saturated              = q7.sat;
      if (q7.mode == esc_pkg::MODE_C2P) begin
        if (q7.big) begin
          res.out_energy_or_pressure = q7.acc[63] ? Q_MIN32 : Q_MAX32;
          res.saturated              = 1'b1;
        end else begin
          res.out_energy_or_pressure = cp.val;
          res.saturated              = q7.sat | cp.sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[TAIL_ST-2:0], in_valid};
      done <= vld[TAIL_ST-1];
    end
    q1     <= n1;
    q2     <= n2;
    q3     <= n3;
    q4     <= n4;
    q5     <= n5;
    q6     <= n6;
    q7     <= n7;
    result <= res;
  end

  `ESC_ASSERT(a_done_follows, done |-> $past(in_valid, TAIL_ST + 1))
  `ESC_ASSERT(a_ke_nonneg, (vld[4] && (q5.mode == esc_pkg::MODE_C2P) && !q5.fault) |-> !q5.ke[63])
  `ESC_ASSERT(a_fault_quiet, (done && result.density_fault) |-> (!result.saturated && (result.out_density == '0) && (result.out_energy_or_pressure == '0)))

endmodule

`default_nettype wire
